/* hdl/mrta_pkg.sv */
// Shared types and codes for the mesh route traffic accumulator.
// No dependencies; imported by mesh_route_traffic_accumulator.
`timescale 1ns / 1ps
`default_nettype none

package mrta_pkg;

  localparam int KIND_W  = 2;
  localparam int COORD_W = 3;
  localparam int PKT_W   = 16;
  localparam int LOAD_W  = 32;
  localparam int CFG_W   = 4;
  localparam int SIZE_W  = 7;   // holds sizes up to 127

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PKT_W-1:0]   pkt_t;
  typedef logic [LOAD_W-1:0]  load_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;
  typedef logic [SIZE_W-1:0]  size_t;

  localparam kind_t KIND_CLEAR = 2'd0;
  localparam kind_t KIND_ROUTE = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  localparam logic REG_MESH_ROWS = 1'b0;
  localparam logic REG_MESH_COLS = 1'b1;

  localparam cfg_data_t MESH_SIZE_RST = 4'd8;

endpackage

`default_nettype wire

/* hdl/mesh_route_traffic_accumulator.sv */
// Per-node packet-load counters for a 2D mesh with dimension-ordered route walk.
// Depends on mrta_pkg; holds the load store as an internal memory.
`timescale 1ns / 1ps
`default_nettype none

// One request is taken when start is high and busy is low; busy stays high
// until the request is finished. A route request visits each node of its path
// with a read step and a saturating add-and-write step on the single load
// store. A read request passes through a store read step and then an output
// step that shows its load for one cycle with out_valid high; the receiver
// cannot stall, so it must take the value then. A clear request, and reset,
// sweep all MAX_ROWS*MAX_COLS entries (64 by default), one per cycle, with
// busy high. A route request with an endpoint outside the mesh in use finishes
// at once; a read outside it still passes through both steps and returns
// load 0; kind 3 is dropped at once.
module mesh_route_traffic_accumulator
  import mrta_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire kind_t     in_kind,
  input  wire coord_t    in_src_row,
  input  wire coord_t    in_src_col,
  input  wire coord_t    in_dst_row,
  input  wire coord_t    in_dst_col,
  input  wire pkt_t      in_packets,
  output logic           out_valid,
  output load_t          out_load,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire cfg_data_t cfg_wdata
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  cfg_data_t         rows_cfg_r, cols_cfg_r;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  coord_t            cur_row_r, cur_row_nxt;
  coord_t            cur_col_r, cur_col_nxt;
  coord_t            dst_row_r, dst_row_nxt;
  coord_t            dst_col_r, dst_col_nxt;
  pkt_t              pkt_r, pkt_nxt;
  logic              oob_r, oob_nxt;
  logic              is_read_r;
  load_t             rd_data_r;

  load_t             mem [0:DEPTH-1];

  size_t             rows_lim, cols_lim;
  logic              accept;
  logic              src_in, dst_in;
  logic [ADDR_W-1:0] node_addr;
  logic [LOAD_W:0]   sum;
  load_t             sat_sum;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  load_t             mem_wdata;

  // Clamp mesh size registers into 1..MAX.
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_lim = size_t'(1);
    end else if (size_t'(rows_cfg_r) > size_t'(MAX_ROWS)) begin
      rows_lim = size_t'(MAX_ROWS);
    end else begin
      rows_lim = size_t'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_lim = size_t'(1);
    end else if (size_t'(cols_cfg_r) > size_t'(MAX_COLS)) begin
      cols_lim = size_t'(MAX_COLS);
    end else begin
      cols_lim = size_t'(cols_cfg_r);
    end
  end

  assign accept = start && !busy;
  assign src_in = (size_t'(in_src_row) < rows_lim) && (size_t'(in_src_col) < cols_lim);
  assign dst_in = (size_t'(in_dst_row) < rows_lim) && (size_t'(in_dst_col) < cols_lim);

  assign node_addr = ADDR_W'(32'(cur_row_r) * 32'(MAX_COLS) + 32'(cur_col_r));

  // Saturating adder for the route add-and-write
  assign sum     = {1'b0, rd_data_r} + (LOAD_W + 1)'(pkt_r);
  assign sat_sum = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];

  assign mem_we    = (state_r == S_CLR) || (state_r == S_WR);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : node_addr;
  assign mem_wdata = (state_r == S_CLR) ? '0 : sat_sum;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    dst_row_nxt = dst_row_r;
    dst_col_nxt = dst_col_r;
    pkt_nxt     = pkt_r;
    oob_nxt     = oob_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cur_row_nxt = in_src_row;
          cur_col_nxt = in_src_col;
          dst_row_nxt = in_dst_row;
          dst_col_nxt = in_dst_col;
          pkt_nxt     = in_packets;
          oob_nxt     = !src_in;
          case (in_kind)
            KIND_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
            KIND_ROUTE: begin
              if (src_in && dst_in) begin
                state_nxt = S_RD;
              end
            end
            // a read goes through the read cycle before the output cycle
            KIND_READ: begin
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = is_read_r ? S_OUT : S_WR;
      end
      S_WR: begin
        // advance along the column leg first, then the row leg; drop when done
        state_nxt = S_RD;
        if (cur_col_r != dst_col_r) begin
          cur_col_nxt = (cur_col_r < dst_col_r) ? cur_col_r + 1'b1 : cur_col_r - 1'b1;
        end else if (cur_row_r != dst_row_r) begin
          cur_row_nxt = (cur_row_r < dst_row_r) ? cur_row_r + 1'b1 : cur_row_r - 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_cnt_r  <= '0;
      rows_cfg_r <= MESH_SIZE_RST;
      cols_cfg_r <= MESH_SIZE_RST;
      oob_r      <= 1'b0;
      is_read_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      oob_r     <= oob_nxt;
      if (state_r == S_IDLE && accept) begin
        is_read_r <= (in_kind == KIND_READ);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MESH_ROWS: rows_cfg_r <= cfg_wdata;
          REG_MESH_COLS: cols_cfg_r <= cfg_wdata;
          default: begin
            rows_cfg_r <= rows_cfg_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    dst_row_r <= dst_row_nxt;
    dst_col_r <= dst_col_nxt;
    pkt_r     <= pkt_nxt;
  end

  // Load store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_RD) begin
      rd_data_r <= mem[node_addr];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_load  = oob_r ? '0 : rd_data_r;

  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_read : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_RD)
    else $error("result shown without a store read");

  a_read_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_READ) |=> busy ##1 out_valid)
    else $error("read request did not return its load");

  a_write_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (32'(node_addr) < DEPTH))
    else $error("route write outside the store");

endmodule

`default_nettype wire

/* test/mrta_load_checker.sv */
// Load checker for the mesh route traffic accumulator: watches request, result and
// config traffic, keeps its own per-node load counters and compares every read.
// Depends on mrta_pkg for field types, request kinds and register indexes.
`timescale 1ns / 1ps

module mrta_load_checker
  import mrta_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  kind_t     in_kind,
  input  coord_t    in_src_row,
  input  coord_t    in_src_col,
  input  coord_t    in_dst_row,
  input  coord_t    in_dst_col,
  input  pkt_t      in_packets,
  input  logic      out_valid,
  input  load_t     out_load,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  cfg_data_t cfg_wdata,
  output int        mismatches,
  output int        waiting,
  output int        compared
);

  localparam int NODES = MAX_ROWS * MAX_COLS;

  load_t     node_load [NODES];
  cfg_data_t rows_reg = MESH_SIZE_RST;
  cfg_data_t cols_reg = MESH_SIZE_RST;
  load_t     pending_loads [$];
  int        fails = 0;
  int        checks = 0;

  // out-of-range sizes act as the nearest legal one
  function automatic int size_in_use(cfg_data_t v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  task automatic add_load(int row, int col, pkt_t amount);
    logic [LOAD_W:0] sum;
    sum = {1'b0, node_load[row * MAX_COLS + col]} + amount;
    node_load[row * MAX_COLS + col] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
  endtask

  // column leg along the source row, then row leg along the target column
  task automatic walk_route(int sr, int sc, int dr, int dc, pkt_t amount);
    int c;
    int r;
    c = sc;
    r = sr;
    add_load(sr, c, amount);
    while (c != dc) begin
      c += (c < dc) ? 1 : -1;
      add_load(sr, c, amount);
    end
    while (r != dr) begin
      r += (r < dr) ? 1 : -1;
      add_load(r, dc, amount);
    end
  endtask

  task automatic report_mismatch(string msg);
    fails++;
    $display("[%0t] load mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    int    rows;
    int    cols;
    load_t want;
    if (!rst_n) begin
      foreach (node_load[i]) node_load[i] = '0;
      rows_reg = MESH_SIZE_RST;
      cols_reg = MESH_SIZE_RST;
      pending_loads.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MESH_ROWS) rows_reg = cfg_wdata;
        else cols_reg = cfg_wdata;
      end
      if (out_valid) begin
        if (pending_loads.size() == 0) begin
          report_mismatch($sformatf("load %h with no read outstanding", out_load));
        end else begin
          want = pending_loads.pop_front();
          checks++;
          if (out_load !== want)
            report_mismatch($sformatf("load got %h, predicted %h", out_load, want));
        end
      end
      if (start && !busy) begin
        rows = size_in_use(rows_reg, MAX_ROWS);
        cols = size_in_use(cols_reg, MAX_COLS);
        case (in_kind)
          KIND_CLEAR: begin
            foreach (node_load[i]) node_load[i] = '0;
          end
          KIND_ROUTE: begin
            if (in_src_row < rows && in_dst_row < rows && in_src_col < cols &&
                in_dst_col < cols)
              walk_route(in_src_row, in_src_col, in_dst_row, in_dst_col, in_packets);
          end
          KIND_READ: begin
            if (in_src_row < rows && in_src_col < cols)
              pending_loads = {pending_loads,
                               node_load[int'(in_src_row) * MAX_COLS + in_src_col]};
            else
              pending_loads = {pending_loads, load_t'(0)};
          end
          default: ;
        endcase
      end
    end
    mismatches <= fails;
    waiting    <= pending_loads.size();
    compared   <= checks;
  end

endmodule

/* test/tb_mesh_route_traffic_accumulator.sv */
// Top of the mesh route traffic accumulator bench: clock, reset, request and
// config stimulus, watchdog and verdict. Depends on mrta_pkg, the accumulator and mrta_load_checker.
`timescale 1ns / 1ps

module tb_mesh_route_traffic_accumulator;
  import mrta_pkg::*;

  localparam kind_t KIND_SPARE     = 2'd3;
  localparam int    MESH_MAX       = 8;
  localparam int    SETTLE_CYCLES  = 80;
  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    SAT_ROUTES     = 8;
  localparam int    SEGMENTS       = 6;
  localparam int    SEG_REQUESTS   = 90;

  logic      clk;
  logic      rst_n      = 1'b0;
  logic      start      = 1'b0;
  kind_t     in_kind    = KIND_CLEAR;
  coord_t    in_src_row = '0;
  coord_t    in_src_col = '0;
  coord_t    in_dst_row = '0;
  coord_t    in_dst_col = '0;
  pkt_t      in_packets = '0;
  logic      cfg_we     = 1'b0;
  logic      cfg_index  = REG_MESH_ROWS;
  cfg_data_t cfg_wdata  = MESH_SIZE_RST;
  logic      busy;
  logic      out_valid;
  load_t     out_load;

  int mismatches;
  int waiting;
  int compared;
  int requests = 0;
  int settings = 0;
  int quiet    = 0;
  int rows_lim = MESH_MAX;
  int cols_lim = MESH_MAX;
  int idle_pct = 0;

  cfg_data_t seg_rows [SEGMENTS] = '{4'd8, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
  cfg_data_t seg_cols [SEGMENTS] = '{4'd8, 4'd8, 4'd1, 4'd0, 4'd15, 4'd6};
  int        seg_idle [SEGMENTS] = '{37, 37, 72, 72, 0, 0};

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  mesh_route_traffic_accumulator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_src_row (in_src_row),
    .in_src_col (in_src_col),
    .in_dst_row (in_dst_row),
    .in_dst_col (in_dst_col),
    .in_packets (in_packets),
    .out_valid  (out_valid),
    .out_load   (out_load),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mrta_load_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_src_row (in_src_row),
    .in_src_col (in_src_col),
    .in_dst_row (in_dst_row),
    .in_dst_col (in_dst_col),
    .in_packets (in_packets),
    .out_valid  (out_valid),
    .out_load   (out_load),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .waiting    (waiting),
    .compared   (compared)
  );

  // any accepted request, result or register write restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int size_in_use(cfg_data_t v);
    if (v == 0) return 1;
    if (int'(v) > MESH_MAX) return MESH_MAX;
    return int'(v);
  endfunction

  // mostly inside the mesh in use, now and then anywhere
  function automatic coord_t pick_coord(int lim);
    if ($urandom_range(9) < 8) return coord_t'($urandom_range(lim - 1));
    return coord_t'($urandom_range(7));
  endfunction

  task automatic send_req(kind_t k, coord_t sr, coord_t sc, coord_t dr, coord_t dc,
                          pkt_t pk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_kind    <= k;
    in_src_row <= sr;
    in_src_col <= sc;
    in_dst_row <= dr;
    in_dst_col <= dc;
    in_packets <= pk;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k != KIND_SPARE &&
        (k != KIND_ROUTE || (sr < rows_lim && dr < rows_lim && sc < cols_lim &&
                             dc < cols_lim)))
      requests++;
  endtask

  // hold off until every read has returned, then let a clear or route finish
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mesh(cfg_data_t rows, cfg_data_t cols);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MESH_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= REG_MESH_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_lim = size_in_use(rows);
    cols_lim = size_in_use(cols);
    settings++;
  endtask

  task automatic random_request();
    int    roll;
    kind_t k;
    pkt_t  pk;
    roll = $urandom_range(99);
    if (roll < 4) k = KIND_CLEAR;
    else if (roll < 10) k = KIND_SPARE;
    else if (roll < 55) k = KIND_ROUTE;
    else k = KIND_READ;
    case ($urandom_range(7))
      0:       pk = '0;
      1:       pk = '1;
      default: pk = pkt_t'($urandom);
    endcase
    if ($urandom_range(99) < 3) drain();
    send_req(k, pick_coord(rows_lim), pick_coord(cols_lim), pick_coord(rows_lim),
             pick_coord(cols_lim), pk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_mesh(MESH_SIZE_RST, MESH_SIZE_RST);

    // full-mesh routes both ways, single node, zero count, spare kind, clear
    send_req(KIND_READ,  0, 0, 0, 0, 16'h0000);
    send_req(KIND_ROUTE, 0, 0, 7, 7, 16'hFFFF);
    send_req(KIND_READ,  0, 7, 0, 0, 16'h0000);
    send_req(KIND_READ,  7, 7, 0, 0, 16'h0000);
    send_req(KIND_READ,  3, 3, 0, 0, 16'h0000);
    send_req(KIND_ROUTE, 7, 7, 0, 0, 16'h0001);
    send_req(KIND_READ,  0, 0, 0, 0, 16'h0000);
    send_req(KIND_READ,  7, 0, 0, 0, 16'h0000);
    send_req(KIND_ROUTE, 4, 4, 4, 4, 16'h0005);
    send_req(KIND_READ,  4, 4, 0, 0, 16'h0000);
    send_req(KIND_ROUTE, 2, 5, 2, 1, 16'h0000);
    send_req(KIND_SPARE, 7, 7, 7, 7, 16'hFFFF);
    send_req(KIND_READ,  2, 3, 0, 0, 16'h0000);
    send_req(KIND_CLEAR, 0, 0, 0, 0, 16'h0000);
    send_req(KIND_READ,  0, 7, 0, 0, 16'h0000);
    send_req(KIND_ROUTE, 5, 2, 1, 6, 16'h0003);
    send_req(KIND_READ,  1, 6, 0, 0, 16'h0000);

    // shrunk mesh: endpoint outside is dropped, reads outside give zero
    set_mesh(4'd3, 4'd2);
    send_req(KIND_ROUTE, 0, 0, 3, 1, 16'h0007);
    send_req(KIND_READ,  1, 6, 0, 0, 16'h0000);
    send_req(KIND_ROUTE, 2, 1, 0, 0, 16'h0009);
    send_req(KIND_READ,  2, 1, 0, 0, 16'h0000);
    set_mesh(4'd0, 4'd15);
    send_req(KIND_ROUTE, 0, 7, 0, 0, 16'h0002);
    send_req(KIND_READ,  0, 4, 0, 0, 16'h0000);
    send_req(KIND_READ,  1, 6, 0, 0, 16'h0000);
    set_mesh(MESH_SIZE_RST, MESH_SIZE_RST);
    send_req(KIND_READ,  1, 6, 0, 0, 16'h0000);

    // pile full-scale counts onto one corner node, then spill onto its neighbor
    repeat (SAT_ROUTES) send_req(KIND_ROUTE, 7, 7, 7, 7, 16'hFFFF);
    send_req(KIND_READ,  7, 7, 0, 0, 16'h0000);
    send_req(KIND_ROUTE, 7, 7, 7, 6, 16'h0001);
    send_req(KIND_READ,  7, 7, 0, 0, 16'h0000);
    send_req(KIND_READ,  7, 6, 0, 0, 16'h0000);

    for (int s = 0; s < SEGMENTS; s++) begin
      set_mesh(seg_rows[s], seg_cols[s]);
      idle_pct = seg_idle[s];
      for (int goal = requests + SEG_REQUESTS; requests < goal; ) random_request();
    end

    idle_pct = 0;
    drain();
    $display("Sent %0d requests over %0d mesh settings, with a %0d-route heavy-load burst;",
             requests, settings, SAT_ROUTES);
    $display("compared %0d node loads against the predicted counters.", compared);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mrta_pkg.sv
hdl/mesh_route_traffic_accumulator.sv
test/mrta_load_checker.sv
test/tb_mesh_route_traffic_accumulator.sv
